// ===== rtl/rdte_pkg.sv =====
`default_nettype none

package rdte_pkg;

    // operand and field widths
    localparam int XLEN    = 32;
    localparam int INSN_W  = 32;
    localparam int PC_W    = 32;
    localparam int REG_W   = 5;
    localparam int OPC_W   = 7;
    localparam int F3_W    = 3;
    localparam int CNT_W   = $clog2(XLEN);

    // instruction decode
    localparam logic [OPC_W-1:0] OPC_OP  = 7'h33;
    localparam logic [PC_W-1:0]  PC_STEP = 32'd4;

    typedef enum logic [F3_W-1:0] {
        F3_DIV  = 3'h4,
        F3_DIVU = 3'h5,
        F3_REM  = 3'h6,
        F3_REMU = 3'h7
    } funct3_t;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic out_load;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic div_op;
        logic count_last;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/rdte_req_if.sv =====
`default_nettype none

interface rdte_req_if
    import rdte_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [INSN_W-1:0] instruction_word;
    logic [XLEN-1:0]   first_operand;
    logic [XLEN-1:0]   second_operand;
    logic [PC_W-1:0]   trap_pc;

    modport source (
        output valid,
        output instruction_word,
        output first_operand,
        output second_operand,
        output trap_pc,
        input  ready
    );

    modport sink (
        input  valid,
        input  instruction_word,
        input  first_operand,
        input  second_operand,
        input  trap_pc,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/rdte_rsp_if.sv =====
`default_nettype none

interface rdte_rsp_if
    import rdte_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             write_enable;
    logic [REG_W-1:0] dest_reg;
    logic [XLEN-1:0]  result_value;
    logic [PC_W-1:0]  next_pc;

    modport source (
        output valid,
        output write_enable,
        output dest_reg,
        output result_value,
        output next_pc,
        input  ready
    );

    modport sink (
        input  valid,
        input  write_enable,
        input  dest_reg,
        input  result_value,
        input  next_pc,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/rv32_divide_trap_emulation.sv =====
`default_nettype none

// Emulates the RV32M divide and remainder instructions for a core that traps
// on them. A request carries the trapped instruction word, rs1, rs2 and the
// trap PC; each request gives exactly one response with write enable, rd,
// result and next PC. For opcode 0x33 with funct3 4..7 (div, divu, rem, remu)
// the result is written, with divide by zero giving all ones (quotient) or the
// dividend (remainder), and -2^31 / -1 giving -2^31 with remainder 0. Other
// funct3 values advance the PC by 4 without a write; other opcodes leave the
// PC unchanged. funct7 is not checked. One request is in work at a time: a
// divide runs the radix-2 restoring divider at one quotient bit per cycle,
// then the sign fix-up result is loaded into the output register; a
// non-divide request passes through the divide state without stepping.
// A new request is taken while the previous response still waits; a
// response that is not taken holds off the next output load.
module rv32_divide_trap_emulation
    import rdte_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    rdte_req_if.sink   request,
    rdte_rsp_if.source response
);

    dp_cmd_t    cmd;
    dp_status_t status;
    logic       req_ready;

    assign request.ready = req_ready;

    // sequencing
    rdte_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (request.valid),
        .req_ready (req_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // divider and output stage
    rdte_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request),
        .response (response),
        .cmd      (cmd),
        .status   (status)
    );

endmodule

`default_nettype wire

// ===== rtl/rdte_ctrl.sv =====
`default_nettype none

module rdte_ctrl
    import rdte_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       req_valid,
    output      logic       req_ready,
    input  wire dp_status_t status,
    output      dp_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (!status.div_op || status.count_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        req_ready    = 1'b0;
        cmd.load     = 1'b0;
        cmd.step     = 1'b0;
        cmd.out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                cmd.load  = req_valid;
            end
            ST_DIVIDE:
            begin
                cmd.step = status.div_op;
            end
            ST_DONE:
            begin
                cmd.out_load = status.out_free;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/rdte_datapath.sv =====
`default_nettype none

module rdte_datapath
    import rdte_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    rdte_req_if.sink        request,
    rdte_rsp_if.source      response,
    input  wire dp_cmd_t    cmd,
    output      dp_status_t status
);

    // decoded item
    logic             we_reg;
    logic             is_rem_reg;
    logic             neg_q_reg;
    logic             neg_r_reg;
    logic             b_zero_reg;
    logic [REG_W-1:0] rd_reg;
    logic [PC_W-1:0]  npc_reg;
    logic [XLEN-1:0]  a_reg;
    logic [XLEN-1:0]  mb_reg;

    // divider
    logic [XLEN-1:0]  rem_reg;
    logic [XLEN-1:0]  quot_reg;
    logic [CNT_W-1:0] cnt_reg;

    // output stage
    logic             out_valid_reg;
    logic             out_we_reg;
    logic [REG_W-1:0] out_rd_reg;
    logic [XLEN-1:0]  out_res_reg;
    logic [PC_W-1:0]  out_npc_reg;

    // input decode
    logic [OPC_W-1:0] opcode;
    logic [F3_W-1:0]  funct3;
    logic             is_op;
    logic             is_div_f3;
    logic             is_signed;
    logic             sa;
    logic             sb;
    logic [XLEN-1:0]  ma;
    logic [XLEN-1:0]  mb;

    assign opcode    = request.instruction_word[OPC_W-1:0];
    assign funct3    = request.instruction_word[14:12];
    assign is_op     = (opcode == OPC_OP);
    assign is_div_f3 = (funct3 == F3_DIV) || (funct3 == F3_DIVU)
                    || (funct3 == F3_REM) || (funct3 == F3_REMU);
    assign is_signed = (funct3 == F3_DIV) || (funct3 == F3_REM);
    assign sa        = is_signed & request.first_operand[XLEN-1];
    assign sb        = is_signed & request.second_operand[XLEN-1];
    assign ma        = sa ? (-request.first_operand) : request.first_operand;
    assign mb        = sb ? (-request.second_operand) : request.second_operand;

    // one restoring step
    logic [XLEN:0]   shifted;
    logic [XLEN:0]   diff;
    logic            q_bit;
    logic [XLEN-1:0] rem_step;

    assign shifted  = {rem_reg, quot_reg[XLEN-1]};
    assign diff     = shifted - {1'b0, mb_reg};
    assign q_bit    = ~diff[XLEN];
    assign rem_step = q_bit ? diff[XLEN-1:0] : shifted[XLEN-1:0];

    // decoded item capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            we_reg     <= is_op & is_div_f3;
            is_rem_reg <= (funct3 == F3_REM) || (funct3 == F3_REMU);
            neg_q_reg  <= sa ^ sb;
            neg_r_reg  <= sa;
            b_zero_reg <= (request.second_operand == '0);
            rd_reg     <= request.instruction_word[11:7];
            npc_reg    <= is_op ? (request.trap_pc + PC_STEP) : request.trap_pc;
            a_reg      <= request.first_operand;
            mb_reg     <= mb;
        end
    end

    // divider iteration
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rem_reg  <= '0;
            quot_reg <= ma;
            cnt_reg  <= CNT_W'(XLEN - 1);
        end
        else if (cmd.step)
        begin
            rem_reg  <= rem_step;
            quot_reg <= {quot_reg[XLEN-2:0], q_bit};
            cnt_reg  <= cnt_reg - CNT_W'(1);
        end
    end

    // sign fix-up and special cases
    logic [XLEN-1:0] q_fix;
    logic [XLEN-1:0] r_fix;
    logic [XLEN-1:0] res;

    assign q_fix = neg_q_reg ? (-quot_reg) : quot_reg;
    assign r_fix = neg_r_reg ? (-rem_reg) : rem_reg;

    always_comb
    begin
        priority if (!we_reg)
        begin
            res = '0;
        end
        else if (b_zero_reg)
        begin
            res = is_rem_reg ? a_reg : '1;
        end
        else
        begin
            res = is_rem_reg ? r_fix : q_fix;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (response.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_we_reg  <= we_reg;
            out_rd_reg  <= rd_reg;
            out_res_reg <= res;
            out_npc_reg <= npc_reg;
        end
    end

    assign response.valid        = out_valid_reg;
    assign response.write_enable = out_we_reg;
    assign response.dest_reg     = out_rd_reg;
    assign response.result_value = out_res_reg;
    assign response.next_pc      = out_npc_reg;

    // status to controller
    assign status.div_op     = we_reg;
    assign status.count_last = (cnt_reg == '0);
    assign status.out_free   = ~out_valid_reg | response.ready;

endmodule

`default_nettype wire
